FILE: src/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

  // bracket kind as held on the stack; KIND_NONE marks a non-bracket byte
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_CURLY  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  // verdict codes
  typedef logic [2:0] status_t;

  localparam status_t ST_BALANCED = 3'd0;
  localparam status_t ST_NO_OPEN  = 3'd1;
  localparam status_t ST_MISMATCH = 3'd2;
  localparam status_t ST_NO_CLOSE = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

  function automatic kind_t open_kind(input logic [7:0] c);
    case (c)
      CH_OPEN_ROUND:  open_kind = KIND_ROUND;
      CH_OPEN_CURLY:  open_kind = KIND_CURLY;
      CH_OPEN_SQUARE: open_kind = KIND_SQUARE;
      default:        open_kind = KIND_NONE;
    endcase
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    case (c)
      CH_CLOSE_ROUND:  close_kind = KIND_ROUND;
      CH_CLOSE_CURLY:  close_kind = KIND_CURLY;
      CH_CLOSE_SQUARE: close_kind = KIND_SQUARE;
      default:         close_kind = KIND_NONE;
    endcase
  endfunction

  // a stored kind outside the three brackets reads as round
  function automatic logic [7:0] opener_of(input kind_t k);
    case (k)
      KIND_CURLY:  opener_of = CH_OPEN_CURLY;
      KIND_SQUARE: opener_of = CH_OPEN_SQUARE;
      default:     opener_of = CH_OPEN_ROUND;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input kind_t k);
    case (k)
      KIND_CURLY:  closer_of = CH_CLOSE_CURLY;
      KIND_SQUARE: closer_of = CH_CLOSE_SQUARE;
      default:     closer_of = CH_CLOSE_ROUND;
    endcase
  endfunction

  function automatic kind_t norm_kind(input kind_t k);
    norm_kind = (k == KIND_NONE) ? KIND_ROUND : k;
  endfunction

endpackage

FILE: src/bbc_ram.sv
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bracket_balance_checker.sv
`timescale 1ns / 1ps

// Input channel (in_valid / in_ready): one beat per byte of an expression,
// with last high on its final byte. Bytes other than ( ) { } [ ] are ignored.
// Output channel (out_valid / out_ready): one beat per expression, carrying
// status (balanced, missing opening, kind mismatch, missing closing, stack
// overflow) and reported_char (the byte that goes with that verdict).
//
// Throughput: one byte per cycle while in_ready is high. The top of the
// stack sits in a register and the entry below it is prefetched every
// cycle from the stack RAM (one write and one registered read port), with
// forwarding when a push writes the entry that is being read, so pushes
// and pops run back to back.
//
// The verdict goes to an output register backed by a one-entry skid buffer;
// in_ready drops only while the skid buffer is full, so bytes keep flowing
// while one verdict waits for the receiver.
//
// Reset clears the count, the latched error and both output stages; the
// stack RAM needs no clearing pass, since only entries below the count are
// read. After each last beat the stack and error are cleared for the next
// expression.

module bracket_balance_checker #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           character,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bbc_pkg::status_t     status,
  output logic [7:0]           reported_char
);

  import bbc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // stack state
  logic [CW-1:0] count, count_next;
  kind_t         top, top_next;
  status_t       err_status, err_status_next;
  logic [7:0]    err_char, err_char_next;

  // stack RAM ports and forwarding
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  kind_t         ram_wdata, ram_rdata;
  logic          fwd;
  kind_t         fwd_data;
  kind_t         below;

  // step decode
  logic          accept;
  kind_t         ok, ck;
  logic          res_valid;
  status_t       res_status;
  logic [7:0]    res_char;

  // output stages
  logic          skid_valid;
  status_t       skid_status;
  logic [7:0]    skid_char;

  bbc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign ok       = open_kind(character);
  assign ck       = close_kind(character);
  assign below    = fwd ? fwd_data : ram_rdata;

  // push / pop on the accepted byte, verdict on the last one
  always_comb begin
    count_next      = count;
    top_next        = top;
    err_status_next = err_status;
    err_char_next   = err_char;
    ram_we          = 1'b0;
    ram_waddr       = AW'(count - CW'(1));
    ram_wdata       = top;
    res_valid       = 1'b0;
    res_status      = ST_BALANCED;
    res_char        = 8'h00;

    if (accept && err_status == ST_BALANCED) begin
      if (ok != KIND_NONE) begin
        if (count >= CW'(STACK_DEPTH)) begin
          err_status_next = ST_OVERFLOW;
          err_char_next   = character;
        end else begin
          // old top spills to RAM, new kind takes the top register
          ram_we     = (count != '0);
          top_next   = ok;
          count_next = count + CW'(1);
        end
      end else if (ck != KIND_NONE) begin
        if (count == '0) begin
          err_status_next = ST_NO_OPEN;
          err_char_next   = character;
        end else begin
          count_next = count - CW'(1);
          top_next   = below;
          if (norm_kind(top) != ck) begin
            err_status_next = ST_MISMATCH;
            err_char_next   = closer_of(norm_kind(top));
          end
        end
      end
    end

    if (accept && last) begin
      res_valid = 1'b1;
      if (err_status_next != ST_BALANCED) begin
        res_status = err_status_next;
        res_char   = err_char_next;
      end else if (count_next != '0) begin
        res_status = ST_NO_CLOSE;
        res_char   = opener_of(norm_kind(top_next));
      end
      count_next      = '0;
      err_status_next = ST_BALANCED;
      err_char_next   = 8'h00;
    end

    // prefetch the entry under the next top
    ram_raddr = AW'(count_next - CW'(2));
  end

  // stack control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      err_status <= ST_BALANCED;
      err_char   <= 8'h00;
      fwd        <= 1'b0;
    end else begin
      count      <= count_next;
      err_status <= err_status_next;
      err_char   <= err_char_next;
      fwd        <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // top of stack and forwarded write data
  always_ff @(posedge clk) begin
    top      <= top_next;
    fwd_data <= ram_wdata;
  end

  // output register with skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid     <= 1'b1;
        status        <= skid_status;
        reported_char <= skid_char;
        skid_valid    <= res_valid;
        skid_status   <= res_status;
        skid_char     <= res_char;
      end else begin
        out_valid     <= res_valid;
        status        <= res_status;
        reported_char <= res_char;
      end
    end else if (res_valid) begin
      skid_valid  <= 1'b1;
      skid_status <= res_status;
      skid_char   <= res_char;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer full while output register empty");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> count == '0 && err_status == ST_BALANCED)
    else $error("stack not cleared after last beat");

  a_overflow_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !last && err_status == ST_BALANCED && ok != KIND_NONE &&
    count == CW'(STACK_DEPTH)
    |=> err_status == ST_OVERFLOW && count == $past(count))
    else $error("overflow did not latch or stack changed");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> out_valid)
    else $error("verdict lost");

endmodule
